>>> design/dvr_pkg.sv
// Shared types and constants for the delta varint32 run decoder.
package dvr_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_VOVF  = 2'd2;
  localparam logic [1:0] ST_SOVF  = 2'd3;

  localparam logic [2:0] LAST_GROUP = 3'd4;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic        last;
  } result_t;

endpackage

>>> design/dvr_if.sv
// Valid/ready channel interfaces: encoded bytes, decoded results, configuration.
interface dvr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_run;
  logic       source_end;

  modport source (output valid, output data_byte, output new_run, output source_end,
                  input ready);
  modport sink (input valid, input data_byte, input new_run, input source_end,
                output ready);
endinterface

interface dvr_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output value, output status, output last, input ready);
  modport sink (input valid, input value, input status, input last, output ready);
endinterface

interface dvr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] run_length;

  modport source (output valid, output run_length, input ready);
  modport sink (input valid, input run_length, output ready);
endinterface

>>> design/delta_varint32_run_decoder_top.sv
// Delta varint32 run decoder: LEB128 bytes in, prefix-summed 32-bit values out.
// One byte per clock is accepted while the decode stage advances. A byte is held
// in the input register, then is decoded and its results enter a 4-entry result
// queue. A byte can produce two results (a value followed by a truncation
// error); the decode stage advances only while the queue has two free slots,
// which is what throttles the input when the result side stalls. run_length is
// written on the cfg channel, which is always ready; a run length of 0 acts as 1.
module delta_varint32_run_decoder_top (
  input logic           clk,
  input logic           rst,
  dvr_byte_if.sink      bytes,
  dvr_cfg_if.sink       cfg,
  dvr_result_if.source  results
);

  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  logic [15:0] run_length;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_new_run;
  logic        in_end;

  logic [31:0] partial_delta;
  logic [2:0]  group_index;
  logic [31:0] running_sum;
  logic        first_pending;
  logic [15:0] values_done;
  logic        error_hold;

  logic [31:0] partial_delta_next;
  logic [2:0]  group_index_next;
  logic [31:0] running_sum_next;
  logic        first_pending_next;
  logic [15:0] values_done_next;
  logic        error_hold_next;

  dvr_pkg::result_t fifo_mem [FifoDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  logic             fire;
  logic             pop;
  logic             push0;
  logic             push1;
  dvr_pkg::result_t res0;
  dvr_pkg::result_t res1;
  logic [31:0]      shifted;
  logic [31:0]      merged;
  logic [32:0]      sum;
  logic [31:0]      val;
  logic [15:0]      vd_inc;
  logic             is_last;
  logic [1:0]       push_cnt;

  assign cfg.ready     = 1'b1;
  assign fire          = in_valid && (count <= CntW'(FifoDepth - 2));
  assign bytes.ready   = !in_valid || fire;
  assign pop           = results.valid && results.ready;
  assign results.valid = (count != '0);
  assign results.value  = fifo_mem[rd_ptr].value;
  assign results.status = fifo_mem[rd_ptr].status;
  assign results.last   = fifo_mem[rd_ptr].last;
  assign push_cnt      = {1'b0, push0} + {1'b0, push1};

  always_comb begin
    partial_delta_next = in_new_run ? '0 : partial_delta;
    group_index_next   = in_new_run ? '0 : group_index;
    running_sum_next   = in_new_run ? '0 : running_sum;
    first_pending_next = in_new_run ? 1'b1 : first_pending;
    values_done_next   = in_new_run ? '0 : values_done;
    error_hold_next    = in_new_run ? 1'b0 : error_hold;
    push0   = 1'b0;
    push1   = 1'b0;
    res0    = '{value: '0, status: dvr_pkg::ST_OK, last: 1'b0};
    res1    = '{value: '0, status: dvr_pkg::ST_TRUNC, last: 1'b1};
    case (group_index_next[1:0])
      2'd0:    shifted = {25'b0, in_byte[6:0]};
      2'd1:    shifted = {18'b0, in_byte[6:0], 7'b0};
      2'd2:    shifted = {11'b0, in_byte[6:0], 14'b0};
      default: shifted = {4'b0, in_byte[6:0], 21'b0};
    endcase
    if (group_index_next >= dvr_pkg::LAST_GROUP) begin
      merged = partial_delta_next | {in_byte[3:0], 28'b0};
    end else begin
      merged = partial_delta_next | shifted;
    end
    sum     = {1'b0, running_sum_next} + {1'b0, merged};
    val     = first_pending_next ? merged : sum[31:0];
    vd_inc  = values_done_next + 16'd1;
    is_last = (vd_inc >= run_length);

    if (!error_hold_next) begin
      if (group_index_next >= dvr_pkg::LAST_GROUP && in_byte[7:4] != 4'd0) begin
        error_hold_next    = 1'b1;
        partial_delta_next = '0;
        group_index_next   = '0;
        push0 = 1'b1;
        res0  = '{value: '0, status: dvr_pkg::ST_VOVF, last: 1'b1};
      end else if (in_byte[7]) begin
        group_index_next   = group_index_next + 3'd1;
        partial_delta_next = merged;
        if (in_end) begin
          error_hold_next    = 1'b1;
          partial_delta_next = '0;
          group_index_next   = '0;
          push0 = 1'b1;
          res0  = '{value: '0, status: dvr_pkg::ST_TRUNC, last: 1'b1};
        end
      end else begin
        partial_delta_next = '0;
        group_index_next   = '0;
        if (!first_pending_next && sum[32]) begin
          error_hold_next = 1'b1;
          push0 = 1'b1;
          res0  = '{value: '0, status: dvr_pkg::ST_SOVF, last: 1'b1};
        end else begin
          running_sum_next   = val;
          first_pending_next = 1'b0;
          values_done_next   = is_last ? '0 : vd_inc;
          push0 = 1'b1;
          res0  = '{value: val, status: dvr_pkg::ST_OK, last: is_last};
          if (in_end && !is_last) begin
            error_hold_next = 1'b1;
            push1 = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length    <= 16'd1;
      in_valid      <= 1'b0;
      partial_delta <= '0;
      group_index   <= '0;
      running_sum   <= '0;
      first_pending <= 1'b1;
      values_done   <= '0;
      error_hold    <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (cfg.valid) begin
        run_length <= cfg.run_length;
      end
      if (bytes.valid && bytes.ready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        partial_delta <= partial_delta_next;
        group_index   <= group_index_next;
        running_sum   <= running_sum_next;
        first_pending <= first_pending_next;
        values_done   <= values_done_next;
        error_hold    <= error_hold_next;
        wr_ptr        <= wr_ptr + PtrW'(push_cnt);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + (fire ? CntW'(push_cnt) : CntW'(0)) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte    <= bytes.data_byte;
      in_new_run <= bytes.new_run;
      in_end     <= bytes.source_end;
    end
    if (fire && push0) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (fire && push1) begin
      fifo_mem[wr_ptr + PtrW'(1)] <= res1;
    end
  end

endmodule
